@@ hdl/pixel_format_converter_unit_defines.svh @@
// assertion macros for the pixel format converter
`ifndef PIXEL_FORMAT_CONVERTER_UNIT_DEFINES_SVH
`define PIXEL_FORMAT_CONVERTER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define PFC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pfc: same-cycle check failed");
// next-cycle implication, checked out of reset
`define PFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pfc: next-cycle check failed");
`else
`define PFC_ASSERT_SAME(label, ante, cons)
`define PFC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ hdl/pfc_pkg.sv @@
// shared types, format codes and helpers for the pixel format converter
package pfc_pkg;

  // pixel format codes
  localparam logic [2:0] FMT_RGBA8  = 3'd0;
  localparam logic [2:0] FMT_RGB8   = 3'd1;
  localparam logic [2:0] FMT_RGBX8  = 3'd2;
  localparam logic [2:0] FMT_BGR8   = 3'd3;
  localparam logic [2:0] FMT_BGRX8  = 3'd4;
  localparam logic [2:0] FMT_BGRA8  = 3'd5;
  localparam logic [2:0] FMT_RGBAI  = 3'd6;
  localparam logic [2:0] FMT_UNUSED = 3'd7;

  // word opcodes
  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_LOAD    = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_SRC_FMT  = 2'd0;
  localparam logic [1:0] REG_DST_FMT  = 2'd1;
  localparam logic [1:0] REG_PAL_MODE = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;
  localparam int unsigned BYTES_W    = 5;

  // converted pixel
  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } pix_t;

  // palette write request
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    pix_t       data;
  } pal_wr_t;

  // palette read request
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
  } pal_rd_t;

  function automatic logic [BYTES_W-1:0] fmt_bytes(input logic [2:0] fmt);
    logic [BYTES_W-1:0] n;
    case (fmt)
      FMT_RGBA8, FMT_RGBX8, FMT_BGRX8, FMT_BGRA8: n = 5'd4;
      FMT_RGB8, FMT_BGR8:                         n = 5'd3;
      FMT_RGBAI:                                  n = 5'd16;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

@@ hdl/pfc_convert.sv @@
// swizzle and clamp of one pixel between packed formats
module pfc_convert
  import pfc_pkg::*;
(
  input  logic [2:0]         src_fmt_i,
  input  logic [2:0]         dst_fmt_i,
  input  logic [63:0]        pix_lo_i,
  input  logic [63:0]        pix_hi_i,
  output pix_t               pix_o,
  output logic [BYTES_W-1:0] bytes_o
);

  function automatic logic [7:0] clamp8(input logic [31:0] v);
    logic [7:0] c;
    if (v[31]) begin
      c = 8'h00;
    end else if (|v[30:8]) begin
      c = 8'hff;
    end else begin
      c = v[7:0];
    end
    return c;
  endfunction

  logic [31:0] r, g, b, a;
  logic [7:0]  cr, cg, cb, ca;

  // unpack source into components
  always_comb begin
    r = '0;
    g = '0;
    b = '0;
    a = '0;
    case (src_fmt_i)
      FMT_RGBA8: begin
        r = {24'd0, pix_lo_i[7:0]};
        g = {24'd0, pix_lo_i[15:8]};
        b = {24'd0, pix_lo_i[23:16]};
        a = {24'd0, pix_lo_i[31:24]};
      end
      FMT_RGB8, FMT_RGBX8: begin
        r = {24'd0, pix_lo_i[7:0]};
        g = {24'd0, pix_lo_i[15:8]};
        b = {24'd0, pix_lo_i[23:16]};
        a = 32'd255;
      end
      FMT_BGR8, FMT_BGRX8: begin
        b = {24'd0, pix_lo_i[7:0]};
        g = {24'd0, pix_lo_i[15:8]};
        r = {24'd0, pix_lo_i[23:16]};
        a = 32'd255;
      end
      FMT_BGRA8: begin
        b = {24'd0, pix_lo_i[7:0]};
        g = {24'd0, pix_lo_i[15:8]};
        r = {24'd0, pix_lo_i[23:16]};
        a = {24'd0, pix_lo_i[31:24]};
      end
      FMT_RGBAI: begin
        r = pix_lo_i[31:0];
        g = pix_lo_i[63:32];
        b = pix_hi_i[31:0];
        a = pix_hi_i[63:32];
      end
      default: begin
      end
    endcase
  end

  assign cr = clamp8(r);
  assign cg = clamp8(g);
  assign cb = clamp8(b);
  assign ca = clamp8(a);

  // pack into destination layout
  always_comb begin
    pix_o = '0;
    if (src_fmt_i == dst_fmt_i) begin
      case (dst_fmt_i)
        FMT_RGBAI: begin
          pix_o.lo = pix_lo_i;
          pix_o.hi = pix_hi_i;
        end
        FMT_RGB8, FMT_BGR8: pix_o.lo = {40'd0, pix_lo_i[23:0]};
        FMT_UNUSED:         pix_o.lo = '0;
        default:            pix_o.lo = {32'd0, pix_lo_i[31:0]};
      endcase
    end else begin
      case (dst_fmt_i)
        FMT_RGBA8:           pix_o.lo = {32'd0, ca, cb, cg, cr};
        FMT_RGB8, FMT_RGBX8: pix_o.lo = {40'd0, cb, cg, cr};
        FMT_BGR8, FMT_BGRX8: pix_o.lo = {40'd0, cr, cg, cb};
        FMT_BGRA8:           pix_o.lo = {32'd0, ca, cr, cg, cb};
        FMT_RGBAI: begin
          pix_o.lo = {g, r};
          pix_o.hi = {a, b};
        end
        default: begin
        end
      endcase
    end
  end

  assign bytes_o = fmt_bytes(dst_fmt_i);

endmodule

@@ hdl/pfc_palette.sv @@
// palette storage: lower and upper word memories, registered read
module pfc_palette
  import pfc_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic    clk_i,
  input  pal_wr_t wr_i,
  input  pal_rd_t rd_i,
  output pix_t    rd_data_o
);

  localparam int unsigned AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [63:0] mem_lower [PALETTE_ENTRIES];
  logic [63:0] mem_upper [PALETTE_ENTRIES];
  logic [63:0] rd_lo_q;
  logic [63:0] rd_hi_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_lower[wr_i.addr[AW-1:0]] <= wr_i.data.lo;
      mem_upper[wr_i.addr[AW-1:0]] <= wr_i.data.hi;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_lo_q <= mem_lower[rd_i.addr[AW-1:0]];
      rd_hi_q <= mem_upper[rd_i.addr[AW-1:0]];
    end
  end

  assign rd_data_o.lo = rd_lo_q;
  assign rd_data_o.hi = rd_hi_q;

endmodule

@@ hdl/pixel_format_converter_unit.sv @@
// top level of the pixel format converter
//
// input channel (in_valid_i/in_ready_o) takes one word per cycle while in_ready_o
// is high: a convert word (opcode_i convert) yields one output word, a load word
// writes one converted palette entry (entry_index_i) and yields nothing
// output channel (out_valid_o/out_ready_i) carries the converted pixel,
// its byte count and the end-of-row flag, in input order
// an accepted word passes the palette read stage, then the output register;
// throughput: one word per cycle while the receiver is not stalled; the palette
// memory reads or writes at most once per accepted word
// a stalled receiver holds the output register; one more word waits in the
// read stage, then in_ready_o drops until the output moves
// config port (cfg_we_i/cfg_idx_i/cfg_wdata_i) sets source format, destination
// format and palette mode; write only while no word is in flight
// reset clears config registers and the pipeline valids; palette entries are
// undefined until loaded and must be loaded before they are indexed
`include "pixel_format_converter_unit_defines.svh"

module pixel_format_converter_unit
  import pfc_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input words
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic [63:0]           pixel_low_i,
  input  logic [63:0]           pixel_high_i,
  input  logic [7:0]            entry_index_i,
  input  logic                  end_of_row_i,
  // output words
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [63:0]           out_low_o,
  output logic [63:0]           out_high_o,
  output logic [BYTES_W-1:0]    out_bytes_o,
  output logic                  row_last_o
);

  // entry count widened to compare against 8-bit indexes
  localparam logic [8:0] NUM_ENTRIES = 9'(PALETTE_ENTRIES);

  // config registers
  logic [2:0] src_fmt_q, src_fmt_d;
  logic [2:0] dst_fmt_q, dst_fmt_d;
  logic       pal_mode_q, pal_mode_d;

  // read stage
  logic               s1_valid_q, s1_valid_d;
  logic               s1_pal_q;
  logic               s1_hit_q;
  pix_t               s1_pix_q;
  logic [BYTES_W-1:0] s1_bytes_q;
  logic               s1_last_q;

  // output register
  logic               out_valid_q, out_valid_d;
  pix_t               out_pix_q;
  logic [BYTES_W-1:0] out_bytes_q;
  logic               out_last_q;

  logic               accept;
  logic               is_convert;
  logic               out_load;
  logic               idx_hit;
  logic               slot_hit;
  pix_t               conv_pix;
  logic [BYTES_W-1:0] conv_bytes;
  pix_t               pal_pix;
  pix_t               s1_out_pix;
  pal_wr_t            pal_wr;
  pal_rd_t            pal_rd;

  // config writes; unknown indexes are dropped
  always_comb begin
    src_fmt_d  = src_fmt_q;
    dst_fmt_d  = dst_fmt_q;
    pal_mode_d = pal_mode_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SRC_FMT:  src_fmt_d  = cfg_wdata_i;
        REG_DST_FMT:  dst_fmt_d  = cfg_wdata_i;
        REG_PAL_MODE: pal_mode_d = cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_fmt_q  <= FMT_RGBA8;
      dst_fmt_q  <= FMT_RGBA8;
      pal_mode_q <= 1'b0;
    end else begin
      src_fmt_q  <= src_fmt_d;
      dst_fmt_q  <= dst_fmt_d;
      pal_mode_q <= pal_mode_d;
    end
  end

  // swizzle/clamp for both direct pixels and palette loads
  pfc_convert u_convert (
    .src_fmt_i (src_fmt_q),
    .dst_fmt_i (dst_fmt_q),
    .pix_lo_i  (pixel_low_i),
    .pix_hi_i  (pixel_high_i),
    .pix_o     (conv_pix),
    .bytes_o   (conv_bytes)
  );

  // handshake: output register frees the read stage, read stage frees input
  assign out_load   = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || out_load;
  assign accept     = in_valid_i && in_ready_o;
  assign is_convert = (opcode_i == OP_CONVERT);

  assign idx_hit  = ({1'b0, pixel_low_i[7:0]} < NUM_ENTRIES);
  assign slot_hit = ({1'b0, entry_index_i} < NUM_ENTRIES);

  // loads write at the accept edge, so a following read sees the new entry
  assign pal_wr.en   = accept && (opcode_i == OP_LOAD) && slot_hit;
  assign pal_wr.addr = entry_index_i;
  assign pal_wr.data = conv_pix;

  assign pal_rd.en   = accept && is_convert && pal_mode_q;
  assign pal_rd.addr = pixel_low_i[7:0];

  pfc_palette #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i     (clk_i),
    .wr_i      (pal_wr),
    .rd_i      (pal_rd),
    .rd_data_o (pal_pix)
  );

  // read stage
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = is_convert;
    end else if (out_load) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_convert) begin
      s1_pal_q   <= pal_mode_q;
      s1_hit_q   <= idx_hit;
      s1_pix_q   <= conv_pix;
      s1_bytes_q <= conv_bytes;
      s1_last_q  <= end_of_row_i;
    end
  end

  // out-of-range palette index gives an all-zero pixel
  always_comb begin
    if (s1_pal_q) begin
      s1_out_pix = s1_hit_q ? pal_pix : '0;
    end else begin
      s1_out_pix = s1_pix_q;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q   <= s1_out_pix;
      out_bytes_q <= s1_bytes_q;
      out_last_q  <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_low_o   = out_pix_q.lo;
  assign out_high_o  = out_pix_q.hi;
  assign out_bytes_o = out_bytes_q;
  assign row_last_o  = out_last_q;

  // both stages full and receiver stalled: no new word may enter
  `PFC_ASSERT_SAME(a_full_blocks_input, s1_valid_q && out_valid_q && !out_ready_i, !in_ready_o)
  // a convert word always reaches the read stage
  `PFC_ASSERT_NEXT(a_convert_enters_s1, accept && is_convert, s1_valid_q)
  // a load word never produces an output word
  `PFC_ASSERT_NEXT(a_load_no_result, accept && !is_convert, !s1_valid_q)
  // palette reads and writes never share a cycle
  `PFC_ASSERT_SAME(a_pal_single_access, pal_wr.en, !pal_rd.en)

endmodule

@@ tb/tb_pixel_format_converter_unit.sv @@
// testbench for the pixel format converter: directed and random words checked against a predictor
module tb_pixel_format_converter_unit;
  import pfc_pkg::*;

  // writes to this index must leave every register alone
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int RANDOM_WORDS   = 1450;
  localparam int WATCHDOG_LIMIT = 5000;
  // pause after the last output word before a config write or the end of the run
  localparam int DRAIN_CYCLES   = 6;

  // one expected output word
  typedef struct {
    logic [63:0]        lo;
    logic [63:0]        hi;
    logic [BYTES_W-1:0] nbytes;
    logic               last;
  } pixel_word_t;

  // dut ports, all inputs known from time zero
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic                  opcode_i      = OP_CONVERT;
  logic [63:0]           pixel_low_i   = '0;
  logic [63:0]           pixel_high_i  = '0;
  logic [7:0]            entry_index_i = '0;
  logic                  end_of_row_i  = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic [63:0]           out_low_o;
  logic [63:0]           out_high_o;
  logic [BYTES_W-1:0]    out_bytes_o;
  logic                  row_last_o;

  // predictor state: config copy, converted palette and which slots hold data
  logic [2:0]  cur_src = FMT_RGBA8;
  logic [2:0]  cur_dst = FMT_RGBA8;
  logic        cur_pal = 1'b0;
  logic [63:0] pal_lo_model [256];
  logic [63:0] pal_hi_model [256];
  bit          slot_loaded  [256];
  logic [7:0]  loaded_slots [$];

  pixel_word_t expected_pixels [$];
  pixel_word_t expected_word;
  int          error_count  = 0;
  int          burst_left   = 0;
  int          stall_left   = 0;
  int          stall_pct    = 0;
  int          idle_cycles  = 0;

  pixel_format_converter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .pixel_low_i   (pixel_low_i),
    .pixel_high_i  (pixel_high_i),
    .entry_index_i (entry_index_i),
    .end_of_row_i  (end_of_row_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_low_o     (out_low_o),
    .out_high_o    (out_high_o),
    .out_bytes_o   (out_bytes_o),
    .row_last_o    (row_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // packed size of each format, unused code gives zero
  function automatic logic [BYTES_W-1:0] format_bytes(input logic [2:0] fmt);
    case (fmt)
      FMT_RGB8, FMT_BGR8: return 5'd3;
      FMT_RGBAI:          return 5'd16;
      FMT_UNUSED:         return 5'd0;
      default:            return 5'd4;
    endcase
  endfunction

  // integer component to an 8-bit channel
  function automatic logic [7:0] clamp_byte(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // copy when the formats match, else unpack the source into r/g/b/a and repack for the destination
  function automatic void convert_pixel(input logic [2:0] sf, input logic [2:0] df,
                                        input logic [63:0] lo, input logic [63:0] hi,
                                        output logic [63:0] olo, output logic [63:0] ohi);
    int         r, g, b, a;
    logic [7:0] cr, cg, cb, ca;
    r   = 0;
    g   = 0;
    b   = 0;
    a   = 0;
    olo = '0;
    ohi = '0;
    if (sf == df) begin
      // same layout: plain copy limited to the format size
      case (format_bytes(df))
        5'd16: begin
          olo = lo;
          ohi = hi;
        end
        5'd4:    olo = {32'd0, lo[31:0]};
        5'd3:    olo = {40'd0, lo[23:0]};
        default: ;
      endcase
    end else begin
      case (sf)
        FMT_RGBA8: begin
          r = 32'(lo[7:0]); g = 32'(lo[15:8]); b = 32'(lo[23:16]); a = 32'(lo[31:24]);
        end
        FMT_RGB8, FMT_RGBX8: begin
          r = 32'(lo[7:0]); g = 32'(lo[15:8]); b = 32'(lo[23:16]); a = 255;
        end
        FMT_BGR8, FMT_BGRX8: begin
          b = 32'(lo[7:0]); g = 32'(lo[15:8]); r = 32'(lo[23:16]); a = 255;
        end
        FMT_BGRA8: begin
          b = 32'(lo[7:0]); g = 32'(lo[15:8]); r = 32'(lo[23:16]); a = 32'(lo[31:24]);
        end
        FMT_RGBAI: begin
          r = lo[31:0]; g = lo[63:32]; b = hi[31:0]; a = hi[63:32];
        end
        default: ;
      endcase
      cr = clamp_byte(r);
      cg = clamp_byte(g);
      cb = clamp_byte(b);
      ca = clamp_byte(a);
      case (df)
        FMT_RGBA8:           olo = {32'd0, ca, cb, cg, cr};
        FMT_RGB8, FMT_RGBX8: olo = {40'd0, cb, cg, cr};
        FMT_BGR8, FMT_BGRX8: olo = {40'd0, cr, cg, cb};
        FMT_BGRA8:           olo = {32'd0, ca, cr, cg, cb};
        FMT_RGBAI: begin
          olo = {g, r};
          ohi = {a, b};
        end
        default: ;
      endcase
    end
  endfunction

  // update the palette copy or queue the expected output for one accepted word
  function automatic void predict_word(input logic op, input logic [63:0] lo,
                                       input logic [63:0] hi, input logic [7:0] slot,
                                       input logic eor);
    pixel_word_t w;
    logic [63:0] clo, chi;
    if (op == OP_LOAD) begin
      // entries are stored already converted, palette mode does not matter
      convert_pixel(cur_src, cur_dst, lo, hi, clo, chi);
      pal_lo_model[slot] = clo;
      pal_hi_model[slot] = chi;
      if (!slot_loaded[slot]) begin
        slot_loaded[slot] = 1'b1;
        loaded_slots.push_back(slot);
      end
    end else begin
      if (cur_pal) begin
        w.lo = pal_lo_model[lo[7:0]];
        w.hi = pal_hi_model[lo[7:0]];
      end else begin
        convert_pixel(cur_src, cur_dst, lo, hi, clo, chi);
        w.lo = clo;
        w.hi = chi;
      end
      w.nbytes = format_bytes(cur_dst);
      w.last   = eor;
      expected_pixels.push_back(w);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // rgbai component biased toward the clamp edges
  function automatic logic [31:0] random_component();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 300) - 20;
      2: begin
        case ($urandom_range(0, 5))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'hffff_ffff;
          3:       return 32'd255;
          4:       return 32'd256;
          default: return 32'd0;
        endcase
      end
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic void random_pixel(input logic [2:0] sf, output logic [63:0] lo,
                                       output logic [63:0] hi);
    if (sf == FMT_RGBAI) begin
      lo = {random_component(), random_component()};
      hi = {random_component(), random_component()};
    end else begin
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
    end
  endfunction

  // unused code now and then, otherwise a real format
  function automatic logic [2:0] random_format();
    if ($urandom_range(0, 11) == 0) return FMT_UNUSED;
    return 3'($urandom_range(0, 6));
  endfunction

  // send one input word, idling between bursts
  task automatic send_word(input logic op, input logic [63:0] lo, input logic [63:0] hi,
                           input logic [7:0] slot, input logic eor);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      // some bursts follow straight on, so long runs go by without a gap
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    pixel_low_i   <= lo;
    pixel_high_i  <= hi;
    entry_index_i <= slot;
    end_of_row_i  <= eor;
    burst_left--;
    // ready is read as it stood at the edge, before the dut updates
    do @(posedge clk_i); while (!in_ready_o);
    predict_word(op, lo, hi, slot, eor);
  endtask

  // hold the sender until every expected word is out and the pipeline is drained
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // program all registers while idle; the spare index is written too and must do nothing
  task automatic program_formats(input logic [2:0] src, input logic [2:0] dst,
                                 input logic [2:0] pal_word);
    logic [2:0] junk;
    junk = 3'($urandom_range(0, 7));
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_SPARE;
    cfg_wdata_i <= junk;
    @(posedge clk_i);
    cfg_idx_i   <= REG_SRC_FMT;
    cfg_wdata_i <= src;
    @(posedge clk_i);
    cfg_idx_i   <= REG_DST_FMT;
    cfg_wdata_i <= dst;
    @(posedge clk_i);
    cfg_idx_i   <= REG_PAL_MODE;
    cfg_wdata_i <= pal_word;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_src = src;
    cur_dst = dst;
    // only bit 0 of the mode register is kept
    cur_pal = pal_word[0];
  endtask

  task automatic convert_with(input logic [2:0] src, input logic [2:0] dst,
                              input logic [63:0] lo, input logic [63:0] hi,
                              input logic eor);
    program_formats(src, dst, 3'b000);
    send_word(OP_CONVERT, lo, hi, 8'd0, eor);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset config is rgba8 to rgba8 without palette: plain copy of four bytes
  task automatic test_reset_defaults();
    send_word(OP_CONVERT, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 8'hff, 1'b1);
    send_word(OP_CONVERT, 64'h0, 64'h0, 8'h00, 1'b0);
  endtask

  // swizzles, forced alpha, clamping, equal formats and the unused code
  task automatic test_format_pairs();
    // negative, above-range and saturated integer components
    convert_with(FMT_RGBAI, FMT_RGBA8, {32'h0000_0100, 32'hffff_ffff},
                 {32'h0000_00ff, 32'h7fff_ffff}, 1'b1);
    convert_with(FMT_RGBAI, FMT_BGRA8, {32'h8000_0000, 32'h0000_00ff},
                 {32'h0000_0000, 32'h0000_0100}, 1'b0);
    // integer copy keeps both halves
    convert_with(FMT_RGBAI, FMT_RGBAI, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1);
    convert_with(FMT_RGBA8, FMT_RGBAI, 64'hdead_beef_80ff_7f01, 64'h1234_5678_9abc_def0, 1'b0);
    // a three-byte source reads alpha as full scale
    convert_with(FMT_RGB8, FMT_BGRA8, 64'hffff_ffff_ff33_2211, 64'h0, 1'b0);
    // x destination leaves alpha clear
    convert_with(FMT_BGRA8, FMT_RGBX8, 64'h0123_4567_aa33_2211, 64'h0, 1'b1);
    convert_with(FMT_BGR8, FMT_BGRX8, 64'hffff_ffff_ff01_0203, 64'h0, 1'b0);
    convert_with(FMT_BGRX8, FMT_BGR8, 64'h5555_5555_ee80_7f00, 64'h0, 1'b1);
    convert_with(FMT_RGBX8, FMT_RGB8, 64'hffff_ffff_ffff_ffff, 64'h0, 1'b0);
    convert_with(FMT_BGRA8, FMT_RGBAI, 64'h0000_0000_f0e0_d0c0, 64'hffff_ffff_ffff_ffff, 1'b1);
    convert_with(FMT_RGBAI, FMT_RGB8, {32'd17, 32'hffff_ff00}, {32'd0, 32'd300}, 1'b0);
    // unused code as source, as destination, and on both sides
    convert_with(FMT_UNUSED, FMT_RGBA8, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1);
    convert_with(FMT_RGBA8, FMT_UNUSED, 64'hffff_ffff_ffff_ffff, 64'h0, 1'b0);
    convert_with(FMT_UNUSED, FMT_UNUSED, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1);
  endtask

  // entries stored converted, looked up by the low index byte, mode bit masking
  task automatic test_palette();
    program_formats(FMT_RGBAI, FMT_RGBA8, 3'b001);
    send_word(OP_LOAD, {32'hffff_ff00, 32'd300}, {32'd128, 32'h7fff_ffff}, 8'd0, 1'b0);
    send_word(OP_LOAD, {32'd17, 32'd0}, {32'hffff_ffff, 32'd200}, 8'd255, 1'b1);
    // upper bits of the index word are ignored
    send_word(OP_CONVERT, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 8'd0, 1'b1);
    send_word(OP_CONVERT, 64'habcd_ef01_2345_6700, 64'h0, 8'd255, 1'b0);
    // mode register keeps only its low bit: this write turns palette mode off
    program_formats(FMT_RGBA8, FMT_BGRA8, 3'b110);
    send_word(OP_CONVERT, 64'h0000_00ff_4433_2211, 64'h0, 8'd0, 1'b1);
  endtask

  // random phases, each with its own config; palette phases mix loads with lookups of slots already loaded
  task automatic test_random_traffic();
    int          sent;
    int          phase_len;
    logic [2:0]  src, dst;
    logic [1:0]  junk;
    logic        pal;
    logic [63:0] lo, hi;
    logic [7:0]  slot;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      src  = random_format();
      dst  = random_format();
      pal  = ($urandom_range(0, 4) < 2);
      junk = 2'($urandom_range(0, 3));
      program_formats(src, dst, {junk, pal});
      phase_len = $urandom_range(10, 80);
      repeat (phase_len) begin
        random_pixel(src, lo, hi);
        if ((pal && (loaded_slots.size() == 0 || $urandom_range(0, 3) == 0)) ||
            (!pal && $urandom_range(0, 6) == 0)) begin
          send_word(OP_LOAD, lo, hi, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
          if (pal) begin
            // only slots loaded since reset may be looked up
            slot = loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
            lo[7:0] = slot;
          end
          send_word(OP_CONVERT, lo, hi, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        end
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_format_pairs();
    test_palette();
    test_random_traffic();
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver, checker, watchdog
  // ---------------------------------------------------------------------------

  // receiver stalls at a randomly chosen rate that changes from time to time, sometimes never
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        2:       stall_pct = 60;
        default: stall_pct = 90;
      endcase
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // compare each output word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        $error("output word with nothing expected: low %h high %h", out_low_o, out_high_o);
        error_count++;
      end else begin
        expected_word = expected_pixels.pop_front();
        check_field("out_low", expected_word.lo, out_low_o);
        check_field("out_high", expected_word.hi, out_high_o);
        check_field("out_bytes", 64'(expected_word.nbytes), 64'(out_bytes_o));
        check_field("row_last", 64'(expected_word.last), 64'(row_last_o));
      end
    end
  end

  // end the run if nothing moves on either channel or the config port for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule

@@ pixel_format_converter_unit.f @@
+incdir+hdl
hdl/pfc_pkg.sv
hdl/pfc_convert.sv
hdl/pfc_palette.sv
hdl/pixel_format_converter_unit.sv
tb/tb_pixel_format_converter_unit.sv
